@@ rtl/hsv2rgb_pkg.sv @@
// Shared constants, types and the color wheel table for the HSV to RGB converter.
package hsv2rgb_pkg;

	localparam int HueW    = 16;
	localparam int FracW   = 12;
	localparam int ChanW   = 13;
	localparam int RecipW  = 20;
	localparam int ScaledW = 15;
	localparam int ProdW   = 25;
	localparam int SectW   = 3;

	localparam logic [HueW-1:0]   HUE_MAX   = 16'd46080;
	localparam logic [ChanW-1:0]  UNIT      = 13'd4096;
	localparam logic [RecipW-1:0] HUE_RECIP = 20'd559147;
	localparam logic [ProdW-1:0]  HALF      = 25'd2048;
	localparam logic [SectW-1:0]  LAST_SECT = 3'd5;

	// Stage enables shared by the hue front end and the channel lanes.
	typedef struct packed {
		logic en_s1;
		logic en_s2;
		logic en_s3;
		logic en_s4;
		logic en_s5;
	} pipe_ctl_t;

	// Primaries as masks: bit 2 red, bit 1 green, bit 0 blue.
	function automatic logic [2:0] wheel(input logic [SectW-1:0] sect);
		logic [2:0] m;
		case (sect)
			3'd0:    m = 3'b100;
			3'd1:    m = 3'b110;
			3'd2:    m = 3'b010;
			3'd3:    m = 3'b011;
			3'd4:    m = 3'b001;
			default: m = 3'b101;
		endcase
		return m;
	endfunction

endpackage

@@ rtl/hsv_to_rgb_converter_core.sv @@
// HSV to RGB converter top level: valid/stall handshake and five-stage pipeline control.
// Depth: five register stages, s1 to s5, between the input and the output port.
// Throughput: one pixel per cycle while the output is not stalled; stages s1 to s5 each
// hold one pixel and a bubble stage fills even while the output is stalled.
// Reset (arst_n, async, active low) clears the stage valid bits only;
// data registers are not reset.
module hsv_to_rgb_converter_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [hsv2rgb_pkg::HueW-1:0]  hue,
	input  logic [hsv2rgb_pkg::ChanW-1:0] saturation,
	input  logic [hsv2rgb_pkg::ChanW-1:0] brightness,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [hsv2rgb_pkg::ChanW-1:0] red,
	output logic [hsv2rgb_pkg::ChanW-1:0] green,
	output logic [hsv2rgb_pkg::ChanW-1:0] blue
);
	import hsv2rgb_pkg::*;

	// Stage valid bits; s5 is the output register.
	logic      vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic      en_s1, en_s2, en_s3, en_s4, en_s5;
	pipe_ctl_t ctl;

	logic [ChanW-1:0] c_s2 [3];
	logic [ChanW-1:0] sat_s2;
	logic [ChanW-1:0] val_s2;
	logic [ChanW-1:0] rgb_s5 [3];

	// A stage loads when it is empty or its content moves on. Bubbles
	// collapse, so upstream keeps filling behind a stalled output.
	assign en_s5 = !vld_s5 || !out_stall;
	assign en_s4 = !vld_s4 || en_s5;
	assign en_s3 = !vld_s3 || en_s4;
	assign en_s2 = !vld_s2 || en_s3;
	assign en_s1 = !vld_s1 || en_s2;

	assign ctl = '{en_s1: en_s1, en_s2: en_s2, en_s3: en_s3, en_s4: en_s4, en_s5: en_s5};

	assign in_stall = !en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (en_s1) vld_s1 <= in_valid;
			if (en_s2) vld_s2 <= vld_s1;
			if (en_s3) vld_s3 <= vld_s2;
			if (en_s4) vld_s4 <= vld_s3;
			if (en_s5) vld_s5 <= vld_s4;
		end
	end

	// s1: clamp and hue * reciprocal; s2: sector, fraction, hue blend.
	hsv2rgb_hue u_hue (
		.clk        (clk),
		.ctl        (ctl),
		.hue        (hue),
		.saturation (saturation),
		.brightness (brightness),
		.c_s2       (c_s2),
		.sat_s2     (sat_s2),
		.val_s2     (val_s2)
	);

	// s3: (1 - c) * s; s4: c1 * v; s5: rounded output register.
	hsv2rgb_to_rgb_converter_core u_lanes (
		.clk    (clk),
		.ctl    (ctl),
		.c_s2   (c_s2),
		.sat_s2 (sat_s2),
		.val_s2 (val_s2),
		.rgb_s5 (rgb_s5)
	);

	assign out_valid = vld_s5;
	assign red       = rgb_s5[0];
	assign green     = rgb_s5[1];
	assign blue      = rgb_s5[2];

endmodule

@@ rtl/hsv2rgb_hue.sv @@
// Hue front end: input clamp, reciprocal scaling and per-channel hue blend.
module hsv2rgb_hue (
	input  logic                          clk,
	input  hsv2rgb_pkg::pipe_ctl_t        ctl,
	input  logic [hsv2rgb_pkg::HueW-1:0]  hue,
	input  logic [hsv2rgb_pkg::ChanW-1:0] saturation,
	input  logic [hsv2rgb_pkg::ChanW-1:0] brightness,
	output logic [hsv2rgb_pkg::ChanW-1:0] c_s2 [3],
	output logic [hsv2rgb_pkg::ChanW-1:0] sat_s2,
	output logic [hsv2rgb_pkg::ChanW-1:0] val_s2
);
	import hsv2rgb_pkg::*;

	logic [HueW-1:0]            h_clamp;
	logic [ChanW-1:0]           s_clamp;
	logic [ChanW-1:0]           v_clamp;
	logic [HueW+RecipW-1:0]     prod;
	logic [ScaledW-1:0]         x_s1;
	logic [ChanW-1:0]           sat_s1;
	logic [ChanW-1:0]           val_s1;
	logic [SectW-1:0]           sect;
	logic [SectW-1:0]           sect_nxt;
	logic [FracW-1:0]           frac;
	logic [2:0]                 mask_a;
	logic [2:0]                 mask_b;
	logic [ChanW-1:0]           c_blend [3];

	assign h_clamp = (hue > HUE_MAX) ? HUE_MAX : hue;
	assign s_clamp = (saturation > UNIT) ? UNIT : saturation;
	assign v_clamp = (brightness > UNIT) ? UNIT : brightness;
	assign prod    = HueW'(h_clamp) * RecipW'(HUE_RECIP);

	always_ff @(posedge clk) begin
		if (ctl.en_s1) begin
			x_s1   <= prod[RecipW +: ScaledW];
			sat_s1 <= s_clamp;
			val_s1 <= v_clamp;
		end
	end

	assign sect     = (x_s1[ScaledW-1 -: SectW] > LAST_SECT) ? LAST_SECT
	                : x_s1[ScaledW-1 -: SectW];
	assign sect_nxt = (sect == LAST_SECT) ? '0 : sect + SectW'(1);
	assign frac     = x_s1[FracW-1:0];
	assign mask_a   = wheel(sect);
	assign mask_b   = wheel(sect_nxt);

	// Channel index 0 red, 1 green, 2 blue.
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			if (mask_a[2-k] == mask_b[2-k])
				c_blend[k] = mask_a[2-k] ? UNIT : '0;
			else if (mask_a[2-k])
				c_blend[k] = UNIT - ChanW'(frac);
			else
				c_blend[k] = ChanW'(frac);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en_s2) begin
			c_s2   <= c_blend;
			sat_s2 <= sat_s1;
			val_s2 <= val_s1;
		end
	end

endmodule

@@ rtl/hsv2rgb_chan.sv @@
// One color channel lane: saturation blend, value blend, rounding.
module hsv2rgb_chan (
	input  logic                          clk,
	input  hsv2rgb_pkg::pipe_ctl_t        ctl,
	input  logic [hsv2rgb_pkg::ChanW-1:0] c_s2,
	input  logic [hsv2rgb_pkg::ChanW-1:0] sat_s2,
	input  logic [hsv2rgb_pkg::ChanW-1:0] val_s2,
	output logic [hsv2rgb_pkg::ChanW-1:0] chan_s5
);
	import hsv2rgb_pkg::*;

	logic [ProdW-1:0] p_s3;
	logic [ChanW-1:0] val_s3;
	logic [ProdW-1:0] p_rnd;
	logic [ChanW-1:0] c1;
	logic [ProdW-1:0] q_s4;
	logic [ProdW-1:0] q_rnd;

	always_ff @(posedge clk) begin
		if (ctl.en_s3) begin
			p_s3   <= ProdW'((UNIT - c_s2) * sat_s2);
			val_s3 <= val_s2;
		end
	end

	assign p_rnd = p_s3 + HALF;
	assign c1    = UNIT - p_rnd[FracW +: ChanW];

	always_ff @(posedge clk) begin
		if (ctl.en_s4)
			q_s4 <= ProdW'(c1 * val_s3);
	end

	assign q_rnd = q_s4 + HALF;

	always_ff @(posedge clk) begin
		if (ctl.en_s5)
			chan_s5 <= q_rnd[FracW +: ChanW];
	end

endmodule

@@ rtl/hsv2rgb_to_rgb_converter_core.sv @@
// Lane bank: the three color channel lanes side by side.
module hsv2rgb_to_rgb_converter_core (
	input  logic                          clk,
	input  hsv2rgb_pkg::pipe_ctl_t        ctl,
	input  logic [hsv2rgb_pkg::ChanW-1:0] c_s2 [3],
	input  logic [hsv2rgb_pkg::ChanW-1:0] sat_s2,
	input  logic [hsv2rgb_pkg::ChanW-1:0] val_s2,
	output logic [hsv2rgb_pkg::ChanW-1:0] rgb_s5 [3]
);
	import hsv2rgb_pkg::*;

	for (genvar k = 0; k < 3; k++) begin : g_lane
		hsv2rgb_chan u_chan (
			.clk     (clk),
			.ctl     (ctl),
			.c_s2    (c_s2[k]),
			.sat_s2  (sat_s2),
			.val_s2  (val_s2),
			.chan_s5 (rgb_s5[k])
		);
	end

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the HSV to RGB pixel converter core.
`timescale 1ns / 100ps

module tb;

	import hsv2rgb_pkg::*;

	// Run length and pacing
	localparam int N_RANDOM    = 850;
	localparam int IDLE_PCT    = 36;     // percent of cycles a side sits idle
	localparam int BURST_FIRST = 300;    // random items in this window run with no gaps
	localparam int BURST_LAST  = 449;
	localparam int DRAIN_WAIT  = 12;     // pipeline is 5 deep, so this is plenty
	localparam int CYCLE_LIMIT = 100000;

	// Primary masks on the color wheel: bit 2 red, bit 1 green, bit 0 blue
	localparam logic [2:0] PRIM_RED     = 3'b100;
	localparam logic [2:0] PRIM_YELLOW  = 3'b110;
	localparam logic [2:0] PRIM_GREEN   = 3'b010;
	localparam logic [2:0] PRIM_CYAN    = 3'b011;
	localparam logic [2:0] PRIM_BLUE    = 3'b001;
	localparam logic [2:0] PRIM_MAGENTA = 3'b101;

	// Fixed reciprocal of 60.01 degrees, with the Q9.7 hue, in units of 2^-20
	localparam logic [35:0] HUE_SCALE = 36'd559147;

	typedef struct packed {
		logic [ChanW-1:0] r;
		logic [ChanW-1:0] g;
		logic [ChanW-1:0] b;
	} rgb_t;

	// One directed transfer; known=1 means the expected color is typed in the row
	typedef struct packed {
		logic [HueW-1:0]  h;
		logic [ChanW-1:0] s;
		logic [ChanW-1:0] v;
		logic             known;
		rgb_t             rgb;
	} pixel_row_t;

	localparam int N_DIRECTED = 25;

	logic             clk        = 1'b0;
	logic             arst_n     = 1'b0;
	logic             in_valid   = 1'b0;
	logic             in_stall;
	logic [HueW-1:0]  hue        = '0;
	logic [ChanW-1:0] saturation = '0;
	logic [ChanW-1:0] brightness = '0;
	logic             out_valid;
	logic             out_stall  = 1'b0;
	logic [ChanW-1:0] red;
	logic [ChanW-1:0] green;
	logic [ChanW-1:0] blue;

	rgb_t       expected_rgb [$];   // colors still owed by the pipeline, oldest first
	pixel_row_t pixel_rows [N_DIRECTED];
	bit         no_gaps = 1'b0;     // both sides run flat out while set
	int         mismatches = 0;
	int         pixels_checked = 0;
	int         cycle_count = 0;

	hsv_to_rgb_converter_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.hue       (hue),
		.saturation(saturation),
		.brightness(brightness),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.red       (red),
		.green     (green),
		.blue      (blue)
	);

	always #1 clk = ~clk;

	// ------------------------------------------------------------------
	// Color predictor
	// ------------------------------------------------------------------

	function automatic logic [2:0] wheel_primary(input logic [2:0] sect);
		case (sect)
			3'd0:    return PRIM_RED;
			3'd1:    return PRIM_YELLOW;
			3'd2:    return PRIM_GREEN;
			3'd3:    return PRIM_CYAN;
			3'd4:    return PRIM_BLUE;
			default: return PRIM_MAGENTA;
		endcase
	endfunction

	// Hue blend between two primaries, then white-to-color by saturation,
	// then black-to-color by value. Both fixed-point blends round half up.
	function automatic logic [ChanW-1:0] shade_channel(input bit a, input bit b,
			input logic [FracW-1:0] t, input logic [ChanW-1:0] s,
			input logic [ChanW-1:0] v);
		logic [ChanW-1:0] c;
		logic [ChanW-1:0] c1;
		logic [25:0]      acc;
		if (a == b) begin
			c = a ? UNIT : '0;
		end else begin
			c = a ? (UNIT - {1'b0, t}) : {1'b0, t};
		end
		acc = (UNIT - c) * s + 26'd2048;
		c1  = UNIT - acc[24:12];
		acc = c1 * v + 26'd2048;
		return acc[24:12];
	endfunction

	function automatic rgb_t hsv_pixel_to_rgb(input logic [HueW-1:0] h_in,
			input logic [ChanW-1:0] s_in, input logic [ChanW-1:0] v_in);
		logic [HueW-1:0]  h;
		logic [ChanW-1:0] s;
		logic [ChanW-1:0] v;
		logic [35:0]      prod;
		logic [15:0]      scaled;
		logic [2:0]       sect;
		logic [FracW-1:0] t;
		logic [2:0]       ca;
		logic [2:0]       cb;
		rgb_t             res;
		// out-of-range inputs clamp
		h = (h_in > HUE_MAX) ? HUE_MAX : h_in;
		s = (s_in > UNIT) ? UNIT : s_in;
		v = (v_in > UNIT) ? UNIT : v_in;
		prod   = h * HUE_SCALE;
		scaled = prod[35:20];
		sect   = scaled[14:12];
		t      = scaled[11:0];
		if (sect > 3'd5)
			sect = 3'd5;
		ca = wheel_primary(sect);
		// magenta wraps back to red
		cb = wheel_primary((sect == 3'd5) ? 3'd0 : sect + 3'd1);
		res.r = shade_channel(ca[2], cb[2], t, s, v);
		res.g = shade_channel(ca[1], cb[1], t, s, v);
		res.b = shade_channel(ca[0], cb[0], t, s, v);
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Input side
	// ------------------------------------------------------------------

	// Random gaps before a transfer, unless in a no-gap stretch
	task automatic idle_sender();
		while (!no_gaps && $urandom_range(0, 99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	// Present one pixel and hold it until the core takes it, then log the color owed
	task automatic send_pixel(input logic [HueW-1:0] h, input logic [ChanW-1:0] s,
			input logic [ChanW-1:0] v, input rgb_t owed);
		idle_sender();
		hue        <= h;
		saturation <= s;
		brightness <= v;
		in_valid   <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		expected_rgb.push_back(owed);
	endtask

	// Mostly legal values; now and then a full-width value (clamp path) or an end point
	function automatic logic [ChanW-1:0] pick_unit();
		int roll;
		roll = $urandom_range(0, 15);
		if (roll == 0)
			return ChanW'($urandom_range(0, 8191));
		if (roll == 1)
			return $urandom_range(0, 1) ? UNIT : '0;
		return ChanW'($urandom_range(0, UNIT));
	endfunction

	function automatic logic [HueW-1:0] pick_hue();
		int roll;
		roll = $urandom_range(0, 15);
		if (roll == 0)
			return HueW'($urandom_range(0, 65535));
		if (roll == 1)
			return $urandom_range(0, 1) ? HUE_MAX : '0;
		return HueW'($urandom_range(0, HUE_MAX));
	endfunction

	initial begin
		logic [HueW-1:0]  h;
		logic [ChanW-1:0] s;
		logic [ChanW-1:0] v;
		rgb_t             owed;

		// Directed rows: primary corners, white/black, clamping, sector edges
		// around each 60 degree step (slightly off because of 60.01), the last
		// sector blending magenta toward red, and alternating bit patterns.
		pixel_rows = '{
			'{16'd0,     13'd4096, 13'd4096, 1'b1, '{13'd4096, 13'd0,    13'd0}},
			'{16'd0,     13'd0,    13'd4096, 1'b1, '{13'd4096, 13'd4096, 13'd4096}},
			'{16'd0,     13'd4096, 13'd0,    1'b1, '{13'd0,    13'd0,    13'd0}},
			'{16'd0,     13'd0,    13'd0,    1'b1, '{13'd0,    13'd0,    13'd0}},
			'{16'd0,     13'd4097, 13'd4097, 1'b1, '{13'd4096, 13'd0,    13'd0}},
			'{16'd0,     13'd0,    13'd8191, 1'b1, '{13'd4096, 13'd4096, 13'd4096}},
			'{16'hFFFF,  13'h1FFF, 13'h1FFF, 1'b0, '0},
			'{16'd46080, 13'd4096, 13'd4096, 1'b0, '0},
			'{16'd46081, 13'd4096, 13'd4096, 1'b0, '0},
			'{16'd7680,  13'd4096, 13'd4096, 1'b0, '0},
			'{16'd7681,  13'd4096, 13'd4096, 1'b0, '0},
			'{16'd15360, 13'd4096, 13'd4096, 1'b0, '0},
			'{16'd23040, 13'd4096, 13'd4096, 1'b0, '0},
			'{16'd30720, 13'd4096, 13'd4096, 1'b0, '0},
			'{16'd38400, 13'd4096, 13'd4096, 1'b0, '0},
			'{16'd3840,  13'd4096, 13'd4096, 1'b0, '0},
			'{16'd19200, 13'd4096, 13'd4096, 1'b0, '0},
			'{16'd26880, 13'd4096, 13'd4096, 1'b0, '0},
			'{16'd34560, 13'd4096, 13'd4096, 1'b0, '0},
			'{16'd42240, 13'd4096, 13'd4096, 1'b0, '0},
			'{16'd11520, 13'd2048, 13'd3000, 1'b0, '0},
			'{16'd30000, 13'd1,    13'd1,    1'b0, '0},
			'{16'h5555,  13'h0AAA, 13'h1555, 1'b0, '0},
			'{16'hAAAA,  13'h1555, 13'h0AAA, 1'b0, '0},
			'{16'd12345, 13'd4095, 13'd4095, 1'b0, '0}
		};

		// Single reset at the start
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (pixel_rows[i]) begin
			owed = pixel_rows[i].known ? pixel_rows[i].rgb :
				hsv_pixel_to_rgb(pixel_rows[i].h, pixel_rows[i].s, pixel_rows[i].v);
			send_pixel(pixel_rows[i].h, pixel_rows[i].s, pixel_rows[i].v, owed);
		end

		for (int n = 0; n < N_RANDOM; n++) begin
			no_gaps = (n >= BURST_FIRST && n <= BURST_LAST);
			h = pick_hue();
			s = pick_unit();
			v = pick_unit();
			send_pixel(h, s, v, hsv_pixel_to_rgb(h, s, v));
		end
		no_gaps = 1'b0;
		in_valid <= 1'b0;

		// Drain; the cycle watchdog catches a result that never shows up
		while (expected_rgb.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("Checked %0d pixels: %0d directed corners and edges, %0d random with clamping.",
			pixels_checked, N_DIRECTED, N_RANDOM);
		$display("Random idles on both ports, plus a back-to-back stretch with no stalls.");
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// ------------------------------------------------------------------
	// Output side: random stalls and the result checker
	// ------------------------------------------------------------------

	task automatic check_chan(input string name, input logic [ChanW-1:0] exp_val,
			input logic [ChanW-1:0] got_val);
		if (got_val !== exp_val) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name,
				exp_val, got_val);
		end
	endtask

	always @(posedge clk) begin
		rgb_t want;
		// Transfer on the output happens with the stall value from before this edge
		if (arst_n && out_valid && !out_stall) begin
			if (expected_rgb.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected pixel out, actual r=%0d g=%0d b=%0d", $time,
					red, green, blue);
			end else begin
				want = expected_rgb.pop_front();
				check_chan("red", want.r, red);
				check_chan("green", want.g, green);
				check_chan("blue", want.b, blue);
				pixels_checked++;
			end
		end
		out_stall <= (!arst_n || no_gaps) ? 1'b0 : ($urandom_range(0, 99) < IDLE_PCT);
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d pixels outstanding", $time, expected_rgb.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

endmodule

@@ filelist.f @@
rtl/hsv2rgb_pkg.sv
rtl/hsv2rgb_hue.sv
rtl/hsv2rgb_chan.sv
rtl/hsv2rgb_to_rgb_converter_core.sv
rtl/hsv_to_rgb_converter_core.sv
tb/tb.sv
